// File: rtl/masked_history_gshare_predictor_core_assert.svh
// Assertion macros used by the predictor core.
`ifndef MASKED_HISTORY_GSHARE_PREDICTOR_CORE_ASSERT_SVH
`define MASKED_HISTORY_GSHARE_PREDICTOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MHG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MHG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MHG_ASSERT_SAME(lbl, ante, cons, msg)
`define MHG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/mhg_pkg.sv
// Shared types, default sizes and the saturating counter step of the predictor.
package mhg_pkg;

  localparam int HISTORY_LENGTH_DEF        = 14;
  localparam int PATTERN_TABLE_SIZE_DEF    = 16384;
  localparam int ADDRESS_TABLE_SIZE_DEF    = 1024;
  localparam int PATTERN_COUNTER_BITS_DEF  = 2;
  localparam int TENDENCY_COUNTER_BITS_DEF = 4;

  typedef enum logic {
    CMD_PREDICT = 1'b0,
    CMD_UPDATE  = 1'b1
  } cmd_t;

  function automatic logic [7:0] sat_step(input logic [7:0] v, input logic up,
                                          input logic [7:0] vmax);
    logic [7:0] r;
    if (up) begin
      r = (v < vmax) ? v + 8'd1 : vmax;
    end else begin
      r = (v > 8'd0) ? v - 8'd1 : 8'd0;
    end
    return r;
  endfunction

endpackage

// File: rtl/mhg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mhg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mhg_entry_update.sv
// Per-address entry update: tendency counter steps and mask recomputation, one lane per history bit.
module mhg_entry_update #(
  parameter int HISTORY_LENGTH        = mhg_pkg::HISTORY_LENGTH_DEF,
  parameter int TENDENCY_COUNTER_BITS = mhg_pkg::TENDENCY_COUNTER_BITS_DEF,
  localparam int EntryWidth = HISTORY_LENGTH + 2 * HISTORY_LENGTH * TENDENCY_COUNTER_BITS
) (
  input  logic [EntryWidth-1:0]     entry,
  input  logic [HISTORY_LENGTH-1:0] hist,
  input  logic                      taken,
  output logic [EntryWidth-1:0]     entry_next
);
  import mhg_pkg::*;

  localparam int H = HISTORY_LENGTH;
  localparam int T = TENDENCY_COUNTER_BITS;
  localparam logic [7:0] TenMax  = 8'((1 << T) - 1);
  localparam logic [7:0] TenHalf = TenMax / 8'd2;

  for (genvar b = 0; b < H; b++) begin : g_lane
    logic [7:0] one_cnt;
    logic [7:0] zero_cnt;
    logic [7:0] one_next;
    logic [7:0] zero_next;
    logic [7:0] diff;

    always_comb begin
      one_cnt  = 8'(entry[H + (2 * b) * T +: T]);
      zero_cnt = 8'(entry[H + (2 * b + 1) * T +: T]);
      one_next  = hist[b] ? sat_step(one_cnt, taken, TenMax) : one_cnt;
      zero_next = hist[b] ? zero_cnt : sat_step(zero_cnt, taken, TenMax);
      diff = (one_next > zero_next) ? one_next - zero_next : zero_next - one_next;
    end

    assign entry_next[b]                     = (diff >= TenHalf);
    assign entry_next[H + (2 * b) * T +: T]     = one_next[T-1:0];
    assign entry_next[H + (2 * b + 1) * T +: T] = zero_next[T-1:0];
  end

endmodule

// File: rtl/masked_history_gshare_predictor_core.sv
// Top level of the masked-history gshare branch predictor.
//
//   channel   handshake            payload
//   command   start / busy         cmd, ip, taken
//   result    done (strobe)        predict_taken
//
// A transaction passes through the address table read (S_ADDR), then the pattern table read
// followed by the write-back (S_PAT); the chained reads of the two memories set this order.
// A new transaction is accepted in the write-back cycle of the previous one; an
// address entry written in that cycle is forwarded to the following read.
// After reset a clearing pass zeroes every entry of both memories while busy stays high;
// its counter is as wide as the address of the larger table.
// The result strobe is registered from the S_PAT state of a predict; updates give none.
module masked_history_gshare_predictor_core #(
  parameter int HISTORY_LENGTH        = mhg_pkg::HISTORY_LENGTH_DEF,
  parameter int PATTERN_TABLE_SIZE    = mhg_pkg::PATTERN_TABLE_SIZE_DEF,
  parameter int ADDRESS_TABLE_SIZE    = mhg_pkg::ADDRESS_TABLE_SIZE_DEF,
  parameter int PATTERN_COUNTER_BITS  = mhg_pkg::PATTERN_COUNTER_BITS_DEF,
  parameter int TENDENCY_COUNTER_BITS = mhg_pkg::TENDENCY_COUNTER_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mhg_pkg::cmd_t cmd,
  input  logic [63:0]   ip,
  input  logic          taken,
  output logic          done,
  output logic          predict_taken
);
  import mhg_pkg::*;

`include "masked_history_gshare_predictor_core_assert.svh"

  localparam int H  = HISTORY_LENGTH;
  localparam int PW = $clog2(PATTERN_TABLE_SIZE);
  localparam int AW = $clog2(ADDRESS_TABLE_SIZE);
  localparam int CW = (PW > AW) ? PW : AW;
  localparam int PC = PATTERN_COUNTER_BITS;
  localparam int EW = H + 2 * H * TENDENCY_COUNTER_BITS;
  localparam logic [7:0] PatMax  = 8'((1 << PC) - 1);
  localparam logic [7:0] PatHalf = PatMax / 8'd2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_PAT
  } state_t;

  state_t        state;
  logic [CW-1:0] clr_cnt;
  logic [H-1:0]  hist;
  cmd_t          cmd_q;
  logic [63:0]   ip_q;
  logic          taken_q;
  logic [AW-1:0] ai_q;
  logic [PW-1:0] pidx_q;
  logic [EW-1:0] ent;
  logic          fwd_hit;
  logic [EW-1:0] fwd_data;

  logic          accept;
  logic          upd_write;
  logic          clearing;
  logic [AW-1:0] ai_in;
  logic [EW-1:0] addr_rdata;
  logic [EW-1:0] entry_rd;
  logic [EW-1:0] entry_next;
  logic [PC-1:0] pat_rdata;
  logic [PW-1:0] pidx;
  logic [63:0]   slice1;
  logic [63:0]   slice2;
  logic [H+PW-1:0] hm_wide;
  logic [7:0]    pat_cnt;
  logic [7:0]    pat_next;

  logic          pat_we;
  logic [PW-1:0] pat_waddr;
  logic [PC-1:0] pat_wdata;
  logic          addr_we;
  logic [AW-1:0] addr_waddr;
  logic [EW-1:0] addr_wdata;

  assign clearing  = (state == S_CLEAR);
  assign busy      = (state == S_CLEAR) || (state == S_ADDR);
  assign accept    = start && !busy;
  assign upd_write = (state == S_PAT) && (cmd_q == CMD_UPDATE);
  assign ai_in     = ip[AW+1:2];

  always_comb begin
    entry_rd = fwd_hit ? fwd_data : addr_rdata;
    slice1   = ip_q >> H;
    slice2   = ip_q >> (2 * H);
    hm_wide  = {{PW{1'b0}}, hist & entry_rd[H-1:0]};
    pidx     = hm_wide[PW-1:0] ^ ip_q[PW-1:0] ^ slice1[PW-1:0] ^ slice2[PW-1:0];
    pat_cnt  = 8'(pat_rdata);
    pat_next = sat_step(pat_cnt, taken_q, PatMax);
  end

  always_comb begin
    pat_we     = clearing || upd_write;
    pat_waddr  = clearing ? clr_cnt[PW-1:0] : pidx_q;
    pat_wdata  = clearing ? '0 : pat_next[PC-1:0];
    addr_we    = clearing || upd_write;
    addr_waddr = clearing ? clr_cnt[AW-1:0] : ai_q;
    addr_wdata = clearing ? '0 : entry_next;
  end

  mhg_ram #(
    .WIDTH (EW),
    .DEPTH (ADDRESS_TABLE_SIZE)
  ) u_addr_ram (
    .clk   (clk),
    .we    (addr_we),
    .waddr (addr_waddr),
    .wdata (addr_wdata),
    .raddr (ai_in),
    .rdata (addr_rdata)
  );

  mhg_ram #(
    .WIDTH (PC),
    .DEPTH (PATTERN_TABLE_SIZE)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_waddr),
    .wdata (pat_wdata),
    .raddr (pidx),
    .rdata (pat_rdata)
  );

  mhg_entry_update #(
    .HISTORY_LENGTH        (H),
    .TENDENCY_COUNTER_BITS (TENDENCY_COUNTER_BITS)
  ) u_entry_update (
    .entry      (ent),
    .hist       (hist),
    .taken      (taken_q),
    .entry_next (entry_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      hist    <= '0;
      done    <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      done    <= (state == S_PAT) && (cmd_q == CMD_PREDICT);
      fwd_hit <= accept && upd_write && (ai_in == ai_q);
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + CW'(1);
          if (clr_cnt == {CW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          state <= S_PAT;
        end
        S_PAT: begin
          if (upd_write) begin
            hist <= H'({hist, taken_q});
          end
          state <= accept ? S_ADDR : S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    predict_taken <= (pat_cnt >= PatHalf);
    fwd_data      <= entry_next;
    if (accept) begin
      cmd_q   <= cmd;
      ip_q    <= ip;
      taken_q <= taken;
      ai_q    <= ai_in;
    end
    if (state == S_ADDR) begin
      ent    <= entry_rd;
      pidx_q <= pidx;
    end
  end

  `MHG_ASSERT_NEXT(a_accept_reads, accept, state == S_ADDR, "Accepted transaction did not start its table read.")
  `MHG_ASSERT_NEXT(a_predict_done, (state == S_PAT) && (cmd_q == CMD_PREDICT), done, "Predict transaction gave no result.")
  `MHG_ASSERT_NEXT(a_update_quiet, (state == S_PAT) && (cmd_q == CMD_UPDATE), !done, "Update transaction gave a result.")
  `MHG_ASSERT_SAME(a_fwd_origin, fwd_hit, state == S_ADDR, "Forwarded entry outside an address read.")

endmodule

// File: sim/masked_history_gshare_predictor_checker.sv
// Checker that mirrors the predictor state from observed transactions and compares each result.
module masked_history_gshare_predictor_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  mhg_pkg::cmd_t cmd,
  input  logic [63:0]   ip,
  input  logic          taken,
  input  logic          done,
  input  logic          predict_taken,
  output int            mismatches,
  output int            outstanding
);
  import mhg_pkg::*;

  localparam int HL       = HISTORY_LENGTH_DEF;
  localparam int PTS      = PATTERN_TABLE_SIZE_DEF;
  localparam int ATS      = ADDRESS_TABLE_SIZE_DEF;
  localparam int PCB      = PATTERN_COUNTER_BITS_DEF;
  localparam int TCB      = TENDENCY_COUNTER_BITS_DEF;
  localparam int PW       = $clog2(PTS);
  localparam int AW       = $clog2(ATS);
  localparam int PAT_MAX  = (1 << PCB) - 1;
  localparam int TEN_MAX  = (1 << TCB) - 1;
  localparam logic [63:0] SLICE = (64'd1 << PW) - 64'd1;

  logic [HL-1:0]  history;
  logic [PCB-1:0] pattern_ctr [PTS];
  logic [HL-1:0]  mask_of     [ATS];
  logic [TCB-1:0] ones_ctr    [ATS][HL];
  logic [TCB-1:0] zeros_ctr   [ATS][HL];
  bit             expected_direction [$];
  int             miss_count = 0;

  function automatic int saturate(input int v, input bit up, input int vmax);
    if (up) begin
      return (v < vmax) ? v + 1 : vmax;
    end
    return (v > 0) ? v - 1 : 0;
  endfunction

  always @(posedge clk) begin
    logic [AW-1:0] entry;
    logic [63:0]   folded;
    logic [PW-1:0] slot;
    logic [HL-1:0] fresh_mask;
    int            diff;
    bit            want;
    if (rst) begin
      history = '0;
      for (int i = 0; i < PTS; i++) pattern_ctr[i] = '0;
      for (int i = 0; i < ATS; i++) begin
        mask_of[i] = '0;
        for (int b = 0; b < HL; b++) begin
          ones_ctr[i][b]  = '0;
          zeros_ctr[i][b] = '0;
        end
      end
      expected_direction.delete();
    end else begin
      if (done) begin
        if (expected_direction.size() == 0) begin
          if (miss_count < 10) begin
            $display("Mismatch: result with no prediction pending, predict_taken=%0b",
                     predict_taken);
          end
          miss_count++;
        end else begin
          want = expected_direction.pop_front();
          if (predict_taken !== want) begin
            if (miss_count < 10) begin
              $display("Mismatch: predict_taken expected %0b, got %0b", want, predict_taken);
            end
            miss_count++;
          end
        end
      end
      if (start && !busy) begin
        entry  = ip[AW+1:2];
        folded = 64'(history & mask_of[entry]) ^ (ip & SLICE) ^ ((ip >> HL) & SLICE)
                 ^ ((ip >> (2 * HL)) & SLICE);
        slot   = folded[PW-1:0];
        if (cmd == CMD_PREDICT) begin
          expected_direction.push_back(int'(pattern_ctr[slot]) >= PAT_MAX / 2);
        end else begin
          pattern_ctr[slot] = PCB'(saturate(int'(pattern_ctr[slot]), taken, PAT_MAX));
          fresh_mask = mask_of[entry];
          for (int b = 0; b < HL; b++) begin
            if (history[b]) begin
              ones_ctr[entry][b] = TCB'(saturate(int'(ones_ctr[entry][b]), taken, TEN_MAX));
            end else begin
              zeros_ctr[entry][b] = TCB'(saturate(int'(zeros_ctr[entry][b]), taken, TEN_MAX));
            end
            diff = int'(ones_ctr[entry][b]) - int'(zeros_ctr[entry][b]);
            if (diff < 0) begin
              diff = -diff;
            end
            fresh_mask[b] = (diff >= TEN_MAX / 2);
          end
          mask_of[entry] = fresh_mask;
          history = {history[HL-2:0], taken};
        end
      end
    end
    mismatches  <= miss_count;
    outstanding <= expected_direction.size();
  end

endmodule

// File: sim/masked_history_gshare_predictor_core_test.sv
// Testbench top that drives predict and update transactions into the predictor and gives the verdict.
module masked_history_gshare_predictor_core_test;
  import mhg_pkg::*;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int RANDOM_ITEMS   = 750;
  localparam int POOL_SIZE      = 16;

  typedef enum int {
    HABIT_TAKEN,
    HABIT_NOT_TAKEN,
    HABIT_REPEAT,
    HABIT_FLIP,
    HABIT_RANDOM
  } habit_t;

  typedef enum int {
    PACE_STEADY,
    PACE_SHORT,
    PACE_WIDE
  } pace_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd = CMD_PREDICT;
  logic [63:0] ip = '0;
  logic        taken = 1'b0;
  logic        done;
  logic        predict_taken;
  int          mismatches;
  int          outstanding;
  int          idle_cycles = 0;

  pace_t       pace = PACE_WIDE;
  int          issued = 0;
  logic        last_outcome = 1'b0;
  logic [63:0] branch_ip    [POOL_SIZE];
  habit_t      branch_habit [POOL_SIZE];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  masked_history_gshare_predictor_core u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .ip            (ip),
    .taken         (taken),
    .done          (done),
    .predict_taken (predict_taken)
  );

  masked_history_gshare_predictor_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .ip            (ip),
    .taken         (taken),
    .done          (done),
    .predict_taken (predict_taken),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // The pacing mode is redrawn every 32 transactions so that long runs without gaps occur.
  task automatic issue(input cmd_t c, input logic [63:0] a, input logic t);
    int gap;
    if (issued % 32 == 0) begin
      pace = pace_t'($urandom_range(0, 2));
    end
    case (pace)
      PACE_STEADY: gap = 0;
      PACE_SHORT:  gap = $urandom_range(0, 2);
      default:     gap = $urandom_range(0, 17);
    endcase
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    ip    <= a;
    taken <= t;
    do @(posedge clk); while (busy);
    if (c == CMD_UPDATE) begin
      last_outcome = t;
    end
    issued++;
  endtask

  task automatic run_branch(input int k);
    logic outcome;
    case (branch_habit[k])
      HABIT_TAKEN:     outcome = 1'b1;
      HABIT_NOT_TAKEN: outcome = 1'b0;
      HABIT_REPEAT:    outcome = last_outcome;
      HABIT_FLIP:      outcome = !last_outcome;
      default:         outcome = 1'($urandom);
    endcase
    issue(CMD_PREDICT, branch_ip[k], 1'($urandom));
    issue(CMD_UPDATE, branch_ip[k], outcome);
  endtask

  initial begin
    for (int k = 0; k < POOL_SIZE; k++) begin
      branch_ip[k]    = {$urandom, $urandom};
      branch_habit[k] = habit_t'(k % 5);
    end
    branch_ip[0] = 64'h0000_0000_0040_1000;
    branch_ip[1] = 64'h0000_0000_0040_1004;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    issue(CMD_PREDICT, 64'h0, 1'b0);
    repeat (4) issue(CMD_UPDATE, 64'h0, 1'b1);
    issue(CMD_PREDICT, 64'h0, 1'b0);
    repeat (4) issue(CMD_UPDATE, 64'h0, 1'b0);
    issue(CMD_PREDICT, 64'h0, 1'b1);
    issue(CMD_PREDICT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    issue(CMD_UPDATE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    issue(CMD_PREDICT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    issue(CMD_PREDICT, 64'h8000_0000_0000_0000, 1'b0);
    issue(CMD_UPDATE, 64'hFFFF_FFFF_0000_0003, 1'b1);
    issue(CMD_PREDICT, 64'h0000_0FFF_FFFF_FFFC, 1'b0);
    issue(CMD_UPDATE, 64'h0000_0000_1000_4001, 1'b0);
    issue(CMD_PREDICT, 64'h0000_0000_1000_4001, 1'b1);

    while (issued < RANDOM_ITEMS + 20) begin
      if ($urandom_range(0, 9) < 8) begin
        run_branch($urandom_range(0, POOL_SIZE - 1));
      end else begin
        issue(cmd_t'($urandom_range(0, 1)), {$urandom, $urandom}, 1'($urandom));
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: masked_history_gshare_predictor_core.f
+incdir+rtl
rtl/mhg_pkg.sv
rtl/mhg_ram.sv
rtl/mhg_entry_update.sv
rtl/masked_history_gshare_predictor_core.sv
sim/masked_history_gshare_predictor_checker.sv
sim/masked_history_gshare_predictor_core_test.sv
